// ===== hdl/rbf_pkg.sv =====
// Shared types and fixed widths of the row box filter.
package rbf_pkg;

  localparam int PIXEL_W     = 8;
  localparam int WIN_W       = 7;
  localparam int HALF_W      = WIN_W - 1;
  localparam int WIN_MAX     = (1 << WIN_W) - 1;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << RECIP_SHIFT;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_in;
    logic               row_end;
  } rbf_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               row_done;
  } rbf_out_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] term;
    logic               last;
    logic [WIN_W-1:0]   win;
    logic [WIN_W-1:0]   gap_win;
    logic [HALF_W-1:0]  gap_half;
  } rbf_cmd_t;

endpackage

// ===== hdl/row_box_filter.sv =====
// Top level of the horizontal box filter over one pixel row.
//
// Pixels enter on the in channel (valid/ready), one transaction per pixel,
// with row_end set on the last pixel of a row. Averaged pixels leave on the
// out channel (valid/ready); row_done marks the last output of a row.
// The window register is written through cfg_wr_en/cfg_wr_data; a new value
// applies from the first pixel of the next row. After each write the
// reciprocal divider runs, and in_ready is low meanwhile. Throughput is one
// pixel per cycle while the divider is idle, no row end is being flushed and
// outputs are taken. A last pixel occupies the summing engine for one step per
// output position it flushes, set by the single read port of the term ring. An
// output passes the input register, queue, step register and output register.
// Reset empties the pipeline and queue, clears the running sum and position,
// and sets the window to 1. The term ring keeps no reset; only entries written
// earlier in the same row are used. When the receiver stalls, the output
// register holds its transaction, and the queue fills before in_ready falls.
module row_box_filter
  import rbf_pkg::*;
#(
  parameter int MAX_WINDOW     = 64,
  parameter int MAX_ROW_LENGTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [WIN_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  rbf_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rbf_out_t         out_data
);

  logic     push_valid;
  logic     push_ready;
  rbf_cmd_t push_cmd;
  logic     pop_valid;
  logic     pop_ready;
  rbf_cmd_t pop_cmd;

  rbf_front #(
    .MAX_WINDOW     (MAX_WINDOW),
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  rbf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  rbf_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/rbf_recip.sv =====
// Serial divider that forms the rounded-up reciprocal of the window length.
module rbf_recip
  import rbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIN_W-1:0]   divisor,
  output logic               busy,
  output logic [RECIP_W-1:0] quotient
);

  localparam int CNT_W = $clog2(RECIP_W + 1);

  logic [RECIP_W-1:0] quo;
  logic [WIN_W-1:0]   rem;
  logic [WIN_W-1:0]   dvs;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  logic [WIN_W:0]     trial;
  logic [WIN_W:0]     diff;
  logic               ge;

  assign trial = {rem, quo[RECIP_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      quo <= RECIP_ONE;
      rem <= '0;
      dvs <= WIN_W'(1);
    end else if (start) begin
      run <= 1'b1;
      cnt <= CNT_W'(RECIP_W);
      quo <= RECIP_ONE + RECIP_W'(divisor) - RECIP_W'(1);
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      rem <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
      quo <= {quo[RECIP_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        run <= 1'b0;
      end
    end
  end

  assign busy     = run;
  assign quotient = quo;

endmodule

// ===== hdl/rbf_front.sv =====
// Input side: window register, per-pixel term and position classification.
module rbf_front
  import rbf_pkg::*;
#(
  parameter int MAX_WINDOW     = 64,
  parameter int MAX_ROW_LENGTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [WIN_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  rbf_in_t          in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output rbf_cmd_t         push_cmd
);

  localparam int WinCap = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
  localparam int POS_W  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int PROD_W = PIXEL_W + RECIP_W;
  localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_ROW_LENGTH);

  logic [WIN_W-1:0]   win_cfg;
  logic [WIN_W-1:0]   act_win;
  logic [RECIP_W-1:0] act_recip;
  logic [POS_W-1:0]   row_pos;

  logic               f1_valid;
  logic [PIXEL_W-1:0] f1_pixel;
  logic               f1_last;
  logic [WIN_W-1:0]   f1_win;
  logic [RECIP_W-1:0] f1_recip;
  logic [POS_W-1:0]   f1_pos;

  logic [WIN_W-1:0]   clamped;
  logic               div_busy;
  logic [RECIP_W-1:0] div_quot;
  logic               row_start;
  logic               accept;
  logic               push;
  logic [PROD_W-1:0]  prod;
  logic [HALF_W-1:0]  half;
  logic [POS_W-1:0]   win_ext;
  logic [POS_W-1:0]   half_ext;

  assign clamped = (cfg_wr_data == '0) ? WIN_W'(1) :
                   (cfg_wr_data > WIN_W'(WinCap)) ? WIN_W'(WinCap) : cfg_wr_data;

  rbf_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_wr_en),
    .divisor  (clamped),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign row_start = row_pos == '0;
  assign push      = f1_valid && push_ready;
  assign in_ready  = !div_busy && (!f1_valid || push_ready);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg  <= WIN_W'(1);
      act_win  <= WIN_W'(1);
      row_pos  <= '0;
      f1_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_cfg <= clamped;
      end
      if (accept) begin
        if (row_start) begin
          act_win <= win_cfg;
        end
        if (in_data.row_end) begin
          row_pos <= '0;
        end else if (row_pos < POS_SAT) begin
          row_pos <= row_pos + POS_W'(1);
        end
        f1_valid <= 1'b1;
      end else if (push) begin
        f1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (row_start) begin
        act_recip <= div_quot;
      end
      f1_pixel <= in_data.pixel_in;
      f1_last  <= in_data.row_end;
      f1_win   <= row_start ? win_cfg : act_win;
      f1_recip <= row_start ? div_quot : act_recip;
      f1_pos   <= row_pos;
    end
  end

  // The term is floor(pixel / window), taken from the scaled reciprocal.
  assign prod     = PROD_W'(f1_pixel) * PROD_W'(f1_recip);
  assign half     = f1_win[WIN_W-1:1];
  assign win_ext  = POS_W'(f1_win);
  assign half_ext = POS_W'(half);

  assign push_valid        = f1_valid;
  assign push_cmd.term     = prod[RECIP_SHIFT +: PIXEL_W];
  assign push_cmd.last     = f1_last;
  assign push_cmd.win      = f1_win;
  assign push_cmd.gap_win  = (f1_pos >= win_ext) ? '0 : WIN_W'(win_ext - f1_pos);
  assign push_cmd.gap_half = (f1_pos >= half_ext) ? '0 : HALF_W'(half_ext - f1_pos);

endmodule

// ===== hdl/rbf_queue.sv =====
// Short command queue between the input side and the summing engine.
module rbf_queue
  import rbf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  rbf_cmd_t push_cmd,
  output logic     pop_valid,
  input  logic     pop_ready,
  output rbf_cmd_t pop_cmd
);

  rbf_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/rbf_back.sv =====
// Summing engine: term ring, running sum, end-of-row flush and output register.
module rbf_back
  import rbf_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  rbf_cmd_t cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output rbf_out_t out_data
);

  localparam int WinCap = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
  localparam int SLOT_W = $clog2(WinCap);
  localparam int RING   = 1 << SLOT_W;

  logic [PIXEL_W-1:0] ring [RING];

  logic [HALF_W-1:0]  flush_idx;
  logic [SLOT_W-1:0]  wslot;
  logic [HALF_W-1:0]  half;
  logic               g_sub;
  logic               g_emit;
  logic               g_write;
  logic               g_final;
  logic               g_done;
  logic [SLOT_W-1:0]  g_slot;
  logic [SLOT_W-1:0]  rd_addr;
  logic               g_adv;

  logic               r_valid;
  logic               r_sub;
  logic               r_emit;
  logic               r_write;
  logic               r_done;
  logic [PIXEL_W-1:0] r_term;
  logic [SLOT_W-1:0]  r_slot;
  logic [PIXEL_W-1:0] mem_q;
  logic               byp;
  logic [PIXEL_W-1:0] byp_data;
  logic [PIXEL_W-1:0] leave;
  logic [PIXEL_W-1:0] sum;
  logic [PIXEL_W-1:0] sum_next;
  logic               r_fire;

  // One step per output position: the pixel step, then the flush steps of a row end.
  assign half    = cmd.win[WIN_W-1:1];
  assign g_sub   = {1'b0, flush_idx} >= cmd.gap_win;
  assign g_emit  = flush_idx >= cmd.gap_half;
  assign g_write = flush_idx == '0;
  assign g_final = !cmd.last || (flush_idx == half);
  assign g_done  = cmd.last && (flush_idx == half);
  assign g_slot  = wslot + SLOT_W'(flush_idx);
  assign rd_addr = g_slot - cmd.win[SLOT_W-1:0];

  assign r_fire    = r_valid && (!r_emit || !out_valid || out_ready);
  assign g_adv     = cmd_valid && (!r_valid || r_fire);
  assign cmd_ready = g_adv && g_final;

  assign leave    = byp ? byp_data : mem_q;
  assign sum_next = sum - (r_sub ? leave : '0) + (r_write ? r_term : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_idx <= '0;
      wslot     <= '0;
      r_valid   <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (g_adv) begin
        flush_idx <= g_final ? '0 : flush_idx + HALF_W'(1);
        if (g_final) begin
          wslot <= cmd.last ? '0 : wslot + SLOT_W'(1);
        end
        r_valid <= 1'b1;
      end else if (r_fire) begin
        r_valid <= 1'b0;
      end
      if (r_fire) begin
        sum <= r_done ? '0 : sum_next;
      end
      if (r_fire && r_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (g_adv) begin
      r_sub   <= g_sub;
      r_emit  <= g_emit;
      r_write <= g_write;
      r_done  <= g_done;
      r_term  <= cmd.term;
      r_slot  <= g_slot;
    end
    if (r_fire && r_emit) begin
      out_data.pixel_out <= sum_next;
      out_data.row_done  <= r_done;
    end
  end

  // The read sees the ring before this edge's write, so a same-slot write is forwarded.
  always_ff @(posedge clk) begin
    if (r_fire && r_write) begin
      ring[r_slot] <= r_term;
    end
    if (g_adv) begin
      mem_q    <= ring[rd_addr];
      byp      <= r_fire && r_write && (r_slot == rd_addr);
      byp_data <= r_term;
    end
  end

endmodule

// ===== hdl/rbf_checker.sv =====
// Port-level checks of the row box filter and their binding to the top level.
module rbf_checker
  import rbf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             cfg_wr_en,
  input logic             in_valid,
  input logic             in_ready,
  input rbf_in_t          in_data,
  input logic             out_valid,
  input logic             out_ready,
  input rbf_out_t         out_data
);

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // A waiting input transaction keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction changed while waiting");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // The reciprocal divider blocks input after a window write.
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> !in_ready)
    else $error("input accepted while the divider runs");

  a_cfg_busy_two: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> ##1 !in_ready)
    else $error("input accepted during the divider run");

endmodule

bind row_box_filter rbf_checker u_rbf_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_wr_en   (cfg_wr_en),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_data     (in_data),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data)
);
